@@ design/kdlsp_pkg.sv @@
// Shared types and constants for the key debounce / long-press unit.
// No dependencies; used by every module of the block.
package kdlsp_pkg;

	localparam int NUM_KEYS    = 4;
	localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
	localparam int DEB_W       = 8;
	localparam int LONG_W      = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_MS          = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LONG_ENABLE_MASK = CFG_IDX_W'(2);

	localparam logic [DEB_W-1:0]    DEBOUNCE_RST = DEB_W'(10);
	localparam logic [LONG_W-1:0]   LONG_RST     = LONG_W'(1000);
	localparam logic [NUM_KEYS-1:0] MASK_RST     = NUM_KEYS'(8);

	// click events produced by one tick: one bit per key
	typedef struct packed {
		logic [NUM_KEYS-1:0] mask;
		logic [NUM_KEYS-1:0] lng;
	} evt_t;

	// live configuration handed to the front end
	typedef struct packed {
		logic [DEB_W-1:0]    debounce_ms;
		logic [LONG_W-1:0]   long_ms;
		logic [NUM_KEYS-1:0] long_enable_mask;
	} cfg_t;

endpackage

@@ design/kdlsp_front.sv @@
// Front end: per-key debounce timers, press/hold tracking, click classification.
// Depends on kdlsp_pkg. Produces one event vector per tick that clicks.
module kdlsp_front #(
	parameter int HOLD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [kdlsp_pkg::NUM_KEYS-1:0] key_levels,
	input  kdlsp_pkg::cfg_t               cfg,
	output logic                          push,
	output kdlsp_pkg::evt_t               evt
);

	localparam int NK = kdlsp_pkg::NUM_KEYS;
	localparam int DW = kdlsp_pkg::DEB_W;
	localparam int CW = (HOLD_WIDTH > kdlsp_pkg::LONG_W) ? HOLD_WIDTH : kdlsp_pkg::LONG_W;
	localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;

	logic [NK-1:0]         prev_q, pressed_q, run_q, rel_q;
	logic [DW-1:0]         dc_q [NK];
	logic [HOLD_WIDTH-1:0] hold_q [NK];

	logic [NK-1:0]         prev_d, pressed_d, run_d, rel_d;
	logic [DW-1:0]         dc_d [NK];
	logic [HOLD_WIDTH-1:0] hold_d [NK];
	logic [NK-1:0]         click, click_long;
	logic [DW-1:0]         arm_val;

	assign arm_val = (cfg.debounce_ms == '0) ? DW'(1) : cfg.debounce_ms;

	always_comb begin
		for (int k = 0; k < NK; k++) begin
			pressed_d[k]  = pressed_q[k];
			run_d[k]      = run_q[k];
			rel_d[k]      = rel_q[k];
			dc_d[k]       = dc_q[k];
			hold_d[k]     = hold_q[k];
			click[k]      = 1'b0;
			click_long[k] = 1'b0;

			if (pressed_q[k] && hold_q[k] != HOLD_MAX) begin
				hold_d[k] = hold_q[k] + HOLD_WIDTH'(1);
			end

			if (run_q[k]) begin
				if (dc_q[k] != '0) begin
					dc_d[k] = dc_q[k] - DW'(1);
				end
				if (dc_d[k] == '0) begin
					run_d[k] = 1'b0;
					if (!rel_q[k]) begin
						if (!key_levels[k]) begin
							pressed_d[k] = 1'b1;
							hold_d[k]    = '0;
						end
					end else if (key_levels[k]) begin
						pressed_d[k]  = 1'b0;
						click_long[k] = CW'(hold_d[k]) > CW'(cfg.long_ms);
						click[k]      = !click_long[k] || cfg.long_enable_mask[k];
					end
				end
			end

			// edge detect; ignored while a timer runs
			if (key_levels[k] != prev_q[k] && !run_d[k]) begin
				if (!key_levels[k]) begin
					run_d[k] = 1'b1;
					rel_d[k] = 1'b0;
					dc_d[k]  = arm_val;
				end else if (pressed_d[k]) begin
					run_d[k] = 1'b1;
					rel_d[k] = 1'b1;
					dc_d[k]  = arm_val;
				end
			end
			prev_d[k] = key_levels[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '1;
			pressed_q <= '0;
			run_q     <= '0;
			rel_q     <= '0;
			for (int k = 0; k < NK; k++) begin
				dc_q[k]   <= '0;
				hold_q[k] <= '0;
			end
		end else if (accept) begin
			prev_q    <= prev_d;
			pressed_q <= pressed_d;
			run_q     <= run_d;
			rel_q     <= rel_d;
			for (int k = 0; k < NK; k++) begin
				dc_q[k]   <= dc_d[k];
				hold_q[k] <= hold_d[k];
			end
		end
	end

	assign push     = accept && (click != '0);
	assign evt.mask = click;
	assign evt.lng  = click_long & click;

endmodule

@@ design/kdlsp_queue.sv @@
// Short event queue between front end and output serializer.
// Depends on kdlsp_pkg (evt_t, QUEUE_DEPTH).
module kdlsp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kdlsp_pkg::evt_t push_evt,
	input  logic            pop,
	output logic            empty,
	output logic            full,
	output kdlsp_pkg::evt_t head
);

	localparam int D  = kdlsp_pkg::QUEUE_DEPTH;
	localparam int PW = kdlsp_pkg::QPTR_W;
	localparam int CW = kdlsp_pkg::QCNT_W;

	kdlsp_pkg::evt_t mem_q [D];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(D));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

@@ design/kdlsp_back.sv @@
// Back end: splits each tick's event vector into click beats, lowest key first.
// Depends on kdlsp_pkg. Drives the registered output channel.
module kdlsp_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  kdlsp_pkg::evt_t                   q_head,
	output logic                              q_pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [kdlsp_pkg::KEY_IDX_W-1:0]   key_index,
	output logic                              long_press,
	output logic                              last_event
);

	localparam int NK = kdlsp_pkg::NUM_KEYS;
	localparam int IW = kdlsp_pkg::KEY_IDX_W;

	logic [NK-1:0] cur_mask_q, cur_lng_q;
	logic          ovld_q;
	logic [IW-1:0] idx_q;
	logic          lng_q, last_q;

	logic          use_cur, load;
	logic [NK-1:0] src_mask, src_lng, pick, rest;
	logic [IW-1:0] sel;

	assign use_cur  = (cur_mask_q != '0);
	assign src_mask = use_cur ? cur_mask_q : (q_empty ? '0 : q_head.mask);
	assign src_lng  = use_cur ? cur_lng_q : q_head.lng;
	assign load     = (!ovld_q || !out_stall) && (src_mask != '0);
	assign q_pop    = load && !use_cur;

	// lowest set key
	always_comb begin
		sel = '0;
		for (int k = NK - 1; k >= 0; k--) begin
			if (src_mask[k]) begin
				sel = IW'(k);
			end
		end
	end

	always_comb begin
		pick = '0;
		pick[sel] = 1'b1;
	end

	assign rest = src_mask & ~pick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q <= '0;
			ovld_q     <= 1'b0;
		end else begin
			if (load) begin
				cur_mask_q <= rest;
				ovld_q     <= 1'b1;
			end else if (!out_stall) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_lng_q <= src_lng;
			idx_q     <= sel;
			lng_q     <= src_lng[sel];
			last_q    <= (rest == '0);
		end
	end

	assign out_valid  = ovld_q;
	assign key_index  = idx_q;
	assign long_press = lng_q;
	assign last_event = last_q;

endmodule

@@ design/key_debounce_long_short_press_unit.sv @@
// Top level of the key debounce / long-press unit: config registers, front end,
// event queue and output serializer. Depends on kdlsp_pkg and the kdlsp_* modules.
//
// Each input beat is one 1 ms tick carrying the raw active-low levels of four
// keys. The front end updates every key's debounce timer and hold counter in the
// cycle the tick is accepted, so ticks go in at one per clock while in_stall is
// low. A tick that ends one or more release debounces with a click pushes one
// event vector into a 4-entry queue; the back end turns it into one output beat
// per click, lowest key first, with last_event set on the final beat of that tick.
// Ticks that produce no click push nothing. A click is registered in the queue
// and then in the output register. Sustained throughput is one tick per cycle
// as long as the output is not stalled and ticks average no more than one click;
// a tick with n clicks takes n output beats, and in_stall rises only while the
// queue is full. Config writes (cfg_valid/cfg_ready, always ready) take effect
// on the next tick and are meant for idle periods only; index 0 debounce_ms
// (0 behaves as 1), 1 long_ms, 2 long_enable_mask, other indexes ignored.
module key_debounce_long_short_press_unit #(
	parameter int HOLD_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// tick input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [kdlsp_pkg::NUM_KEYS-1:0]     key_levels,
	// click output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [kdlsp_pkg::KEY_IDX_W-1:0]    key_index,
	output logic                               long_press,
	output logic                               last_event,
	// config write
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kdlsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kdlsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	kdlsp_pkg::cfg_t cfg_q;
	kdlsp_pkg::evt_t push_evt, q_head;
	logic            accept, push, q_pop, q_empty, q_full;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms      <= kdlsp_pkg::DEBOUNCE_RST;
			cfg_q.long_ms          <= kdlsp_pkg::LONG_RST;
			cfg_q.long_enable_mask <= kdlsp_pkg::MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kdlsp_pkg::REG_DEBOUNCE_MS: begin
					cfg_q.debounce_ms <= cfg_data[kdlsp_pkg::DEB_W-1:0];
				end
				kdlsp_pkg::REG_LONG_MS: begin
					cfg_q.long_ms <= cfg_data[kdlsp_pkg::LONG_W-1:0];
				end
				kdlsp_pkg::REG_LONG_ENABLE_MASK: begin
					cfg_q.long_enable_mask <= cfg_data[kdlsp_pkg::NUM_KEYS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// a tick is taken whenever the queue has room for its events
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	kdlsp_front #(
		.HOLD_WIDTH(HOLD_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.key_levels (key_levels),
		.cfg        (cfg_q),
		.push       (push),
		.evt        (push_evt)
	);

	kdlsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (push_evt),
		.pop      (q_pop),
		.empty    (q_empty),
		.full     (q_full),
		.head     (q_head)
	);

	kdlsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_index  (key_index),
		.long_press (long_press),
		.last_event (last_event)
	);

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for key_debounce_long_short_press_unit: random key waveforms
// with bounce, scored against an in-bench model of the debounce and hold timers.
// Depends on kdlsp_pkg and the design sources.
module tb_top;

	localparam int NUM_KEYS   = kdlsp_pkg::NUM_KEYS;
	localparam int KEY_IDX_W  = kdlsp_pkg::KEY_IDX_W;
	localparam int DEB_W      = kdlsp_pkg::DEB_W;
	localparam int LONG_W     = kdlsp_pkg::LONG_W;
	localparam int CFG_IDX_W  = kdlsp_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = kdlsp_pkg::CFG_DATA_W;

	localparam int HOLD_W   = 16;
	localparam int SETTLE   = 10;    // cycles after the last click before touching config
	localparam int HOLD_OFF = 300;   // one long output stall to fill the event queue
	localparam int STUCK_MAX = 4000; // cycles with no beat on any channel

	typedef struct packed {
		logic                 prev_lvl;
		logic                 pressed;
		logic                 armed;
		logic                 for_rel;
		logic [DEB_W-1:0]     deb_left;
		logic [HOLD_W-1:0]    held;
	} key_state_t;

	typedef struct packed {
		logic [KEY_IDX_W-1:0] key;
		logic                 lng;
		logic                 last_ev;
	} click_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [NUM_KEYS-1:0]   key_levels = '1;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KEY_IDX_W-1:0]  key_index;
	logic                  long_press;
	logic                  last_event;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	key_state_t keys [NUM_KEYS];
	logic [DEB_W-1:0]    deb_ticks = kdlsp_pkg::DEBOUNCE_RST;
	logic [LONG_W-1:0]   long_thr  = kdlsp_pkg::LONG_RST;
	logic [NUM_KEYS-1:0] long_en   = kdlsp_pkg::MASK_RST;

	logic [NUM_KEYS-1:0] tick_q [$];   // ticks waiting for the driver
	click_t              click_q [$];  // clicks the model says are on their way
	click_t              want;

	int ticks_sent = 0;
	int ticks_taken = 0;
	int fails = 0;
	int stuck = 0;
	bit tick_taken = 1'b0;

	// stimulus generator: per-key level and remaining run length
	logic [NUM_KEYS-1:0] gen_lvl = '1;
	int run_left [NUM_KEYS];

	// pacing
	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int stall_calm = 0;
	int hold_left = 0;
	bit want_hold = 1'b0;
	bit hold_started = 1'b0;

	key_debounce_long_short_press_unit #(
		.HOLD_WIDTH(HOLD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_levels(key_levels),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_index(key_index),
		.long_press(long_press),
		.last_event(last_event),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then long, and
	// occasional calm stretches where no gap is inserted at all.
	function automatic int gap_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Register write as the block sees it; unknown indexes are dropped.
	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			kdlsp_pkg::REG_DEBOUNCE_MS:      deb_ticks = val[DEB_W-1:0];
			kdlsp_pkg::REG_LONG_MS:          long_thr  = val[LONG_W-1:0];
			kdlsp_pkg::REG_LONG_ENABLE_MASK: long_en   = val[NUM_KEYS-1:0];
			default: ;
		endcase
	endfunction

	// One 1 ms tick through every key: hold count first, then the debounce
	// timer (judged on this tick's level), then edge detection, which may
	// re-arm a timer in the same tick it expired. Clicks go out lowest key first.
	function automatic void predict_clicks(input logic [NUM_KEYS-1:0] levels);
		click_t batch [NUM_KEYS];
		int     n;
		int     k;
		logic   lvl;
		logic   is_long;
		n = 0;
		for (k = 0; k < NUM_KEYS; k++) begin
			lvl = levels[k];
			if (keys[k].pressed && keys[k].held != '1)
				keys[k].held = keys[k].held + 1'b1;
			if (keys[k].armed) begin
				if (keys[k].deb_left != '0)
					keys[k].deb_left = keys[k].deb_left - 1'b1;
				if (keys[k].deb_left == '0) begin
					keys[k].armed = 1'b0;
					if (!keys[k].for_rel) begin
						// press confirmed: hold time restarts, even on a key already down
						if (!lvl) begin
							keys[k].pressed = 1'b1;
							keys[k].held = '0;
						end
					end else if (lvl) begin
						is_long = keys[k].held > long_thr;
						keys[k].pressed = 1'b0;
						// long clicks on a masked-off key vanish
						if (!is_long || long_en[k]) begin
							batch[n].key = KEY_IDX_W'(k);
							batch[n].lng = is_long;
							batch[n].last_ev = 1'b0;
							n++;
						end
					end
					// a failed debounce just drops the timer
				end
			end
			// edges are ignored while a timer runs, but the level is still tracked
			if (lvl != keys[k].prev_lvl && !keys[k].armed && (!lvl || keys[k].pressed)) begin
				keys[k].armed = 1'b1;
				keys[k].for_rel = lvl;
				keys[k].deb_left = (deb_ticks == '0) ? DEB_W'(1) : deb_ticks;
			end
			keys[k].prev_lvl = lvl;
		end
		for (k = 0; k < n; k++) begin
			batch[k].last_ev = (k == n - 1);
			click_q.push_back(batch[k]);
		end
	endfunction

	// Waveform per key: runs of constant level, mostly long enough to survive
	// the debounce, about one in five a short bounce that may not.
	function automatic logic [NUM_KEYS-1:0] next_levels(input int deb, input int spread);
		int k;
		int eff;
		eff = (deb == 0) ? 1 : deb;
		for (k = 0; k < NUM_KEYS; k++) begin
			if (run_left[k] == 0) begin
				gen_lvl[k] = ~gen_lvl[k];
				if ($urandom_range(0, 4) == 0)
					run_left[k] = $urandom_range(1, eff);
				else
					run_left[k] = eff + 1 + $urandom_range(0, spread);
			end
			run_left[k] = run_left[k] - 1;
		end
		return gen_lvl;
	endfunction

	// ---------------------------------------------------------------- driver
	// A new tick goes out at the falling edge once the previous beat was taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || tick_taken)) begin
			if (send_gap > 0) begin
				send_gap = send_gap - 1;
				in_valid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				key_levels <= tick_q.pop_front();
				in_valid <= 1'b1;
				ticks_sent++;
				send_gap = gap_len(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------- output stalls
	// Random stalls, plus one long hold-off on request so the event queue fills
	// and the block has to push back on its tick input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (want_hold && !hold_started) begin
				hold_started = 1'b1;
				hold_left = HOLD_OFF;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left = stall_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = gap_len(stall_calm);
			end
		end
	end

	// --------------------------------------------------------------- monitor
	always @(posedge clk) begin
		if (arst_n) begin
			tick_taken = in_valid && !in_stall;
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (tick_taken) begin
				predict_clicks(key_levels);
				ticks_taken++;
			end
			if (out_valid && !out_stall) begin
				if (click_q.size() == 0) begin
					$error("unexpected click beat: key_index %0d long_press %0d last_event %0d",
						key_index, long_press, last_event);
					fails++;
				end else begin
					want = click_q.pop_front();
					if (key_index !== want.key) begin
						$error("key_index: expected %0d, got %0d", want.key, key_index);
						fails++;
					end
					if (long_press !== want.lng) begin
						$error("long_press: expected %0d, got %0d", want.lng, long_press);
						fails++;
					end
					if (last_event !== want.last_ev) begin
						$error("last_event: expected %0d, got %0d", want.last_ev, last_event);
						fails++;
					end
				end
			end
		end
	end

	// -------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				stuck = 0;
			else
				stuck++;
			if (stuck >= STUCK_MAX) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Block is quiet: every tick taken, every click seen, plus a settling wait for
	// ticks still in flight that end in no click.
	task automatic wait_idle();
		while (!(tick_q.size() == 0 && ticks_taken == ticks_sent && click_q.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// All three registers; unused upper data bits are random, and now and then
	// a write to an index past the last register is thrown in.
	task automatic set_regs(input int deb, input int lim, input logic [NUM_KEYS-1:0] en);
		logic [CFG_DATA_W-1:0] val;
		wait_idle();
		val = CFG_DATA_W'($urandom);
		val[DEB_W-1:0] = DEB_W'(deb);
		write_reg(kdlsp_pkg::REG_DEBOUNCE_MS, val);
		write_reg(kdlsp_pkg::REG_LONG_MS, CFG_DATA_W'(lim));
		val = CFG_DATA_W'($urandom);
		val[NUM_KEYS-1:0] = en;
		write_reg(kdlsp_pkg::REG_LONG_ENABLE_MASK, val);
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_IDX_W'($urandom_range(kdlsp_pkg::REG_LONG_ENABLE_MASK + 1,
				2**CFG_IDX_W - 1)), CFG_DATA_W'($urandom));
	endtask

	task automatic run_phase(input int deb, input int lim, input logic [NUM_KEYS-1:0] en,
			input int len, input int spread);
		set_regs(deb, lim, en);
		repeat (len) tick_q.push_back(next_levels(deb, spread));
	endtask

	// -------------------------------------------------------------- sequence
	initial begin
		logic [NUM_KEYS-1:0] script [22];
		int k;
		int deb;

		for (k = 0; k < NUM_KEYS; k++) begin
			keys[k] = '0;
			keys[k].prev_lvl = 1'b1;
			run_left[k] = $urandom_range(0, 5);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, zero debounce (acts as one tick), long above 3, long only on keys 0/2:
		//  all four pressed and released together -> four short clicks in one tick,
		//  then held past the threshold -> long on keys 0 and 2, dropped on 1 and 3,
		//  a press that bounces back up before it settles,
		//  a release that fails and turns into a fresh press, which restarts the hold.
		set_regs(0, 3, 4'h5);
		script = '{4'hF, 4'h0, 4'h0, 4'hF, 4'hF,
			4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF,
			4'hE, 4'hF,
			4'hE, 4'hE, 4'hF, 4'hE, 4'hE, 4'hF, 4'hF};
		for (k = 0; k < 22; k++)
			tick_q.push_back(script[k]);

		// Random waveforms over a spread of settings, extremes first.
		run_phase(1, 0, 4'hA, 30, 6);         // nearly every click long; keys 1/3 only
		run_phase(1, 4, 4'hF, 40, 6);
		want_hold = 1'b1;                     // output held off while ticks keep coming
		run_phase(3, 65534, 4'hF, 24, 10);    // threshold out of reach
		repeat (2) begin
			deb = $urandom_range(1, 6);
			run_phase(deb, $urandom_range(0, deb + 12), NUM_KEYS'($urandom), 25, 10);
		end

		wait_idle();
		if (click_q.size() != 0) begin
			$error("%0d expected clicks never arrived", click_q.size());
			fails++;
		end
		if (fails == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
